// ----- hw/rtl/u8sv_pkg.sv -----
// shared types, constants and helpers for the utf-8 stream validator
package u8sv_pkg;

   localparam int COUNT_WIDTH  = 32;
   localparam int TOTAL_WIDTH  = 32;
   localparam int POINT_WIDTH  = 21;
   localparam int STATUS_WIDTH = 4;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_PENDING  = 4'd0,
      ST_ASCII    = 4'd1,
      ST_MULTI    = 4'd2,
      ST_BADHEAD  = 4'd3,
      ST_BADTAIL  = 4'd4,
      ST_OVERLONG = 4'd5,
      ST_BADPOINT = 4'd6,
      ST_BADEND   = 4'd7,
      ST_ENDOK    = 4'd8,
      ST_STOPPED  = 4'd9
   } status_type;

   // sequence lengths kept in the decode state
   localparam logic [2:0] LEN_IDLE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   localparam logic [POINT_WIDTH-1:0] CP_TWO_MIN   = 21'h00_0080;
   localparam logic [POINT_WIDTH-1:0] CP_TWO_MAX   = 21'h00_07FF;
   localparam logic [POINT_WIDTH-1:0] CP_THREE_MIN = 21'h00_0800;
   localparam logic [POINT_WIDTH-1:0] CP_SURR_LO   = 21'h00_D800;
   localparam logic [POINT_WIDTH-1:0] CP_SURR_HI   = 21'h00_DFFF;
   localparam logic [POINT_WIDTH-1:0] CP_THREE_MAX = 21'h00_FFFF;
   localparam logic [POINT_WIDTH-1:0] CP_FOUR_MIN  = 21'h01_0000;
   localparam logic [POINT_WIDTH-1:0] CP_MAX       = 21'h10_FFFF;

   // decode state carried from one byte to the next
   typedef struct packed {
      logic [1:0]             tails_left;
      logic [2:0]             seq_len;
      logic [POINT_WIDTH-1:0] point;
      logic                   halted;
   } dec_state_type;

   // what the decode step asks of the counters
   typedef struct packed {
      logic ascii_inc;
      logic multi_inc;
   } count_ctl_type;

   function automatic logic [TOTAL_WIDTH-1:0] to_total(input logic [COUNT_WIDTH-1:0] c);
      logic [63:0] wide;
      wide = 64'(c);
      return wide[TOTAL_WIDTH-1:0];
   endfunction

endpackage

// ----- hw/rtl/u8sv_sat_counter.sv -----
// saturating event counter
module u8sv_sat_counter
   import u8sv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   inc,
   output logic [COUNT_WIDTH-1:0] count_in
);

   logic [COUNT_WIDTH-1:0] count_ff;

   // value after this request, also what the result reports
   always_comb begin
      count_in = count_ff;
      if (inc && (count_ff != {COUNT_WIDTH{1'b1}})) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/u8sv_step.sv -----
// one byte of utf-8 decoding: next state and status for a request
module u8sv_step
   import u8sv_pkg::*;
(
   input  logic [7:0]             data_byte,
   input  logic                   end_of_stream,
   input  dec_state_type          cur,
   output dec_state_type          nxt,
   output count_ctl_type          ctl,
   output status_type             status,
   output logic [POINT_WIDTH-1:0] detail
);

   logic [POINT_WIDTH-1:0] acc;
   logic [1:0]             tails_dec;
   status_type             verdict;

   assign acc       = {cur.point[POINT_WIDTH-7:0], data_byte[5:0]};
   assign tails_dec = cur.tails_left - 2'd1;

   // range check of a completed sequence
   always_comb begin
      case (cur.seq_len)
         LEN_TWO: begin
            verdict = (acc >= CP_TWO_MIN && acc <= CP_TWO_MAX) ? ST_MULTI : ST_OVERLONG;
         end
         LEN_THREE: begin
            if (acc < CP_THREE_MIN) begin
               verdict = ST_OVERLONG;
            end else if (acc >= CP_SURR_LO && acc <= CP_SURR_HI) begin
               verdict = ST_BADPOINT;
            end else if (acc <= CP_THREE_MAX) begin
               verdict = ST_MULTI;
            end else begin
               verdict = ST_OVERLONG;
            end
         end
         default: begin
            if (acc < CP_FOUR_MIN) begin
               verdict = ST_OVERLONG;
            end else if (acc > CP_MAX) begin
               verdict = ST_BADPOINT;
            end else begin
               verdict = ST_MULTI;
            end
         end
      endcase
   end

   always_comb begin
      nxt    = cur;
      ctl    = '0;
      status = ST_STOPPED;
      detail = '0;
      if (cur.halted) begin
         status = ST_STOPPED;
      end else if (end_of_stream) begin
         nxt.halted = 1'b1;
         if (cur.tails_left != 2'd0) begin
            status = ST_BADEND;
            detail = cur.point;
         end else begin
            status = ST_ENDOK;
         end
      end else if (cur.tails_left == 2'd0) begin
         // header byte
         if (data_byte[7] == 1'b0) begin
            ctl.ascii_inc = 1'b1;
            status        = ST_ASCII;
            detail        = POINT_WIDTH'(data_byte);
         end else if (data_byte[7:5] == 3'b110) begin
            nxt.point      = POINT_WIDTH'(data_byte[4:0]);
            nxt.seq_len    = LEN_TWO;
            nxt.tails_left = 2'd1;
            status         = ST_PENDING;
            detail         = nxt.point;
         end else if (data_byte[7:4] == 4'b1110) begin
            nxt.point      = POINT_WIDTH'(data_byte[3:0]);
            nxt.seq_len    = LEN_THREE;
            nxt.tails_left = 2'd2;
            status         = ST_PENDING;
            detail         = nxt.point;
         end else if (data_byte[7:3] == 5'b11110) begin
            nxt.point      = POINT_WIDTH'(data_byte[2:0]);
            nxt.seq_len    = LEN_FOUR;
            nxt.tails_left = 2'd3;
            status         = ST_PENDING;
            detail         = nxt.point;
         end else begin
            nxt.halted = 1'b1;
            status     = ST_BADHEAD;
            detail     = POINT_WIDTH'(data_byte);
         end
      end else if (data_byte[7:6] != 2'b10) begin
         nxt.halted = 1'b1;
         status     = ST_BADTAIL;
         detail     = POINT_WIDTH'(data_byte);
      end else begin
         // tail byte
         nxt.point      = acc;
         nxt.tails_left = tails_dec;
         detail         = acc;
         if (tails_dec != 2'd0) begin
            status = ST_PENDING;
         end else begin
            status      = verdict;
            nxt.seq_len = LEN_IDLE;
            if (verdict == ST_MULTI) begin
               ctl.multi_inc = 1'b1;
            end else begin
               nxt.halted = 1'b1;
            end
         end
      end
   end

endmodule

// ----- hw/rtl/utf8_stream_validator.sv -----
// top level of the utf-8 stream validator
//
//  port group | dir | handshake             | payload
//  req_       | in  | req_valid / req_ready | data_byte (8), end_of_stream (1)
//  rsp_       | out | rsp_valid / rsp_ready | status (4), detail_value (21),
//             |     |                       | ascii_total (32), multibyte_total (32)
//
// one request per cycle sustained while rsp_ready is high; a taken request
// passes through the input register, then the result register, before its
// response is valid
// the decode step sits between the input register and the result register
// reset clears decode state, counters and both valid flags
// a stalled response holds the result register; the input register keeps
// its request and req_ready drops only when both stages are full and
// rsp_ready is low
module utf8_stream_validator
   import u8sv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_end_of_stream,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [POINT_WIDTH-1:0]  rsp_detail_value,
   output logic [TOTAL_WIDTH-1:0]  rsp_ascii_total,
   output logic [TOTAL_WIDTH-1:0]  rsp_multibyte_total
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   // result register
   logic                   out_valid_ff;
   status_type             out_status_ff;
   logic [POINT_WIDTH-1:0] out_detail_ff;
   logic [TOTAL_WIDTH-1:0] out_ascii_ff;
   logic [TOTAL_WIDTH-1:0] out_multi_ff;

   // decode state
   dec_state_type state_ff;
   dec_state_type state_in;

   count_ctl_type          ctl;
   status_type             step_status;
   logic [POINT_WIDTH-1:0] step_detail;
   logic [COUNT_WIDTH-1:0] ascii_in;
   logic [COUNT_WIDTH-1:0] multi_in;

   logic out_free;
   logic advance;

   // result register can take a new value when empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   // the request in the input register moves to the result register
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   u8sv_step u_step (
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .cur           (state_ff),
      .nxt           (state_in),
      .ctl           (ctl),
      .status        (step_status),
      .detail        (step_detail)
   );

   u8sv_sat_counter u_ascii_cnt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .inc      (ctl.ascii_inc),
      .count_in (ascii_in)
   );

   u8sv_sat_counter u_multi_cnt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .inc      (ctl.multi_inc),
      .count_in (multi_in)
   );

   // control flags and decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
      if (advance) begin
         out_status_ff <= step_status;
         out_detail_ff <= step_detail;
         // totals report the counts after this request
         out_ascii_ff  <= to_total(ascii_in);
         out_multi_ff  <= to_total(multi_in);
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_detail_value    = out_detail_ff;
   assign rsp_ascii_total     = out_ascii_ff;
   assign rsp_multibyte_total = out_multi_ff;

endmodule
